### src/ip_address_text_classifier_macros.svh
// ----------------------------------------------------------------------------
// ip_address_text_classifier_macros
// assertion macros used by the classifier top level
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled in reset
`define IATC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IATC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/iatc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iatc_pkg
// types and constants for the ip address text classifier
// ----------------------------------------------------------------------------
package iatc_pkg;

    localparam int CountWidth = 32;
    localparam int TotalWidth = 32;

    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;
    localparam logic [7:0] CharLoA   = 8'h61;
    localparam logic [7:0] CharLoF   = 8'h66;

    localparam logic [8:0]  V4FieldMax = 9'd255;
    localparam logic [8:0]  V4FieldSat = 9'd256;
    localparam logic [2:0]  V4Dots     = 3'd3;
    localparam logic [2:0]  DotSat     = 3'd7;
    localparam logic [3:0]  V6Colons   = 4'd7;
    localparam logic [3:0]  ColonSat   = 4'd15;
    localparam logic [2:0]  HexMax     = 3'd4;

    typedef enum logic [1:0] {
        CLASS_IPV4    = 2'd0,
        CLASS_IPV6    = 2'd1,
        CLASS_INVALID = 2'd2
    } t_addr_class;

    typedef struct packed {
        logic       v4_possible;
        logic [2:0] dot_count;
        logic       v4_empty;
        logic [8:0] v4_value;
        logic       v4_lead_zero;
        logic       v6_possible;
        logic [3:0] colon_count;
        logic [2:0] hex_count;
    } t_line_state;

    localparam t_line_state LineClear = '{
        v4_possible:  1'b1,
        dot_count:    3'd0,
        v4_empty:     1'b1,
        v4_value:     9'd0,
        v4_lead_zero: 1'b0,
        v6_possible:  1'b1,
        colon_count:  4'd0,
        hex_count:    3'd0
    };

endpackage

### src/iatc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iatc_scan
// per-character update of the ipv4 and ipv6 line checks and the line verdict
// ----------------------------------------------------------------------------
module iatc_scan import iatc_pkg::*; (
    input  t_line_state i_state,
    input  logic [7:0]  i_char_code,
    output t_line_state o_next,
    output t_addr_class o_class
);

    logic        is_dot;
    logic        is_colon;
    logic        is_digit;
    logic        is_hex;
    logic [3:0]  digit;
    logic [11:0] v4_prod;
    logic [8:0]  v4_sat;
    logic [2:0]  dot_inc;
    logic [3:0]  colon_inc;
    logic        v4_ok;
    logic        v6_ok;

    assign is_dot   = (i_char_code == CharDot);
    assign is_colon = (i_char_code == CharColon);
    assign is_digit = (i_char_code >= CharZero) && (i_char_code <= CharNine);
    assign is_hex   = is_digit
                    || ((i_char_code >= CharUpA) && (i_char_code <= CharUpF))
                    || ((i_char_code >= CharLoA) && (i_char_code <= CharLoF));
    assign digit    = i_char_code[3:0];

    // value * 10 + digit, saturating
    assign v4_prod  = ({3'b000, i_state.v4_value} << 3)
                    + ({3'b000, i_state.v4_value} << 1)
                    + {8'h00, digit};
    assign v4_sat   = (v4_prod > {3'b000, V4FieldSat}) ? V4FieldSat : v4_prod[8:0];

    assign dot_inc   = (i_state.dot_count < DotSat) ? i_state.dot_count + 3'd1
                                                    : i_state.dot_count;
    assign colon_inc = (i_state.colon_count < ColonSat) ? i_state.colon_count + 4'd1
                                                        : i_state.colon_count;

    always_comb begin
        o_next = i_state;
        // ipv4 side
        if (is_dot) begin
            if (i_state.v4_empty || (i_state.v4_value > V4FieldMax) || (dot_inc > V4Dots)) begin
                o_next.v4_possible = 1'b0;
            end
            o_next.dot_count    = dot_inc;
            o_next.v4_empty     = 1'b1;
            o_next.v4_value     = 9'd0;
            o_next.v4_lead_zero = 1'b0;
        end else if (is_digit) begin
            if (i_state.v4_lead_zero || (v4_sat > V4FieldMax)) begin
                o_next.v4_possible = 1'b0;
            end
            if (i_state.v4_empty && (digit == 4'd0)) begin
                o_next.v4_lead_zero = 1'b1;
            end
            o_next.v4_value = v4_sat;
            o_next.v4_empty = 1'b0;
        end else begin
            o_next.v4_possible = 1'b0;
        end
        // ipv6 side
        if (is_colon) begin
            if ((i_state.hex_count == 3'd0) || (colon_inc > V6Colons)) begin
                o_next.v6_possible = 1'b0;
            end
            o_next.colon_count = colon_inc;
            o_next.hex_count   = 3'd0;
        end else if (is_hex) begin
            if (i_state.hex_count >= HexMax) begin
                o_next.v6_possible = 1'b0;
            end else begin
                o_next.hex_count = i_state.hex_count + 3'd1;
            end
        end else begin
            o_next.v6_possible = 1'b0;
        end
    end

    assign v4_ok = i_state.v4_possible && (i_state.dot_count == V4Dots)
                && !i_state.v4_empty && (i_state.v4_value <= V4FieldMax);
    assign v6_ok = i_state.v6_possible && (i_state.colon_count == V6Colons)
                && (i_state.hex_count >= 3'd1) && (i_state.hex_count <= HexMax);

    always_comb begin
        if (v4_ok) begin
            o_class = CLASS_IPV4;
        end else if (v6_ok) begin
            o_class = CLASS_IPV6;
        end else begin
            o_class = CLASS_INVALID;
        end
    end

endmodule

### src/ip_address_text_classifier.sv
`timescale 1ns / 1ps
// an end-of-line word is held in the stage-one register, then its result is registered
// throughput: one word per cycle while the input is not stalled; character words give no result
// the only stall is an end-of-line word held while the result register is full
// reset (synchronous, active low) clears line state, counters and valids
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// classifies each text line as ipv4, ipv6 or invalid and keeps class totals
// ----------------------------------------------------------------------------
`include "ip_address_text_classifier_macros.svh"

module ip_address_text_classifier import iatc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_char_code,
    input  logic                  i_line_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_address_class,
    output logic [TotalWidth-1:0] o_ipv4_total,
    output logic [TotalWidth-1:0] o_ipv6_total,
    output logic [TotalWidth-1:0] o_invalid_total
);

    logic                  r_s1_valid;
    logic [7:0]            r_s1_char;
    logic                  r_s1_end;
    t_line_state           r_line;
    t_line_state           n_line;
    t_line_state           scan_next;
    t_addr_class           scan_class;
    logic [CountWidth-1:0] r_cnt_v4;
    logic [CountWidth-1:0] r_cnt_v6;
    logic [CountWidth-1:0] r_cnt_bad;
    logic [CountWidth-1:0] n_cnt_v4;
    logic [CountWidth-1:0] n_cnt_v6;
    logic [CountWidth-1:0] n_cnt_bad;
    logic                  r_out_valid;
    t_addr_class           r_out_class;
    logic [TotalWidth-1:0] r_out_v4;
    logic [TotalWidth-1:0] r_out_v6;
    logic [TotalWidth-1:0] r_out_bad;
    logic                  out_free;
    logic                  s1_fire;
    logic                  end_fire;

    iatc_scan u_scan (
        .i_state     (r_line),
        .i_char_code (r_s1_char),
        .o_next      (scan_next),
        .o_class     (scan_class)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1_end || out_free);
    assign end_fire   = s1_fire && r_s1_end;
    assign o_in_ready = !r_s1_valid || s1_fire;

    assign n_line = r_s1_end ? LineClear : scan_next;

    always_comb begin
        n_cnt_v4  = r_cnt_v4;
        n_cnt_v6  = r_cnt_v6;
        n_cnt_bad = r_cnt_bad;
        if (end_fire) begin
            case (scan_class)
                CLASS_IPV4: begin
                    if (r_cnt_v4 != {CountWidth{1'b1}}) begin
                        n_cnt_v4 = r_cnt_v4 + CountWidth'(1);
                    end
                end
                CLASS_IPV6: begin
                    if (r_cnt_v6 != {CountWidth{1'b1}}) begin
                        n_cnt_v6 = r_cnt_v6 + CountWidth'(1);
                    end
                end
                default: begin
                    if (r_cnt_bad != {CountWidth{1'b1}}) begin
                        n_cnt_bad = r_cnt_bad + CountWidth'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_line      <= LineClear;
            r_cnt_v4    <= '0;
            r_cnt_v6    <= '0;
            r_cnt_bad   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_line <= n_line;
            end
            r_cnt_v4  <= n_cnt_v4;
            r_cnt_v6  <= n_cnt_v6;
            r_cnt_bad <= n_cnt_bad;
            if (end_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_char <= i_char_code;
            r_s1_end  <= i_line_end;
        end
        if (end_fire) begin
            r_out_class <= scan_class;
            r_out_v4    <= TotalWidth'(n_cnt_v4);
            r_out_v6    <= TotalWidth'(n_cnt_v6);
            r_out_bad   <= TotalWidth'(n_cnt_bad);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_address_class = r_out_class;
    assign o_ipv4_total    = r_out_v4;
    assign o_ipv6_total    = r_out_v6;
    assign o_invalid_total = r_out_bad;

    `IATC_ASSERT_NXT(a_end_gives_word, end_fire, r_out_valid, "line end produced no word")
    `IATC_ASSERT_NXT(a_one_counter, 1'b1, $onehot0({r_cnt_v4 != $past(r_cnt_v4), r_cnt_v6 != $past(r_cnt_v6), r_cnt_bad != $past(r_cnt_bad)}), "more than one counter moved")
    `IATC_ASSERT_IMP(a_stall_cause, !o_in_ready, r_s1_valid && r_s1_end && r_out_valid && !i_out_ready, "input stalled without a held line end")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// feeds text lines to the ip address classifier one word per character plus an
// end-of-line word, and checks every line verdict and the three class totals
// against a predictor kept inside the bench; a table of corner-case lines comes
// first, then random well-formed and broken addresses, with the sender working
// in bursts and the receiver stalling on a pattern of its own
// ----------------------------------------------------------------------------
module testbench;
    import iatc_pkg::*;

    localparam int CycleLimit     = 200000;
    localparam int RandomWords    = 220;
    localparam int MinRandomLines = 12;
    localparam int ByModel        = -1;
    localparam int DirRows        = 22;

    typedef logic [7:0] t_text [$];

    typedef struct {
        t_addr_class           cls;
        logic [TotalWidth-1:0] v4_total;
        logic [TotalWidth-1:0] v6_total;
        logic [TotalWidth-1:0] bad_total;
    } t_verdict;

    typedef enum int {
        FLOW_FREE,
        FLOW_HALF,
        FLOW_SPARSE
    } t_flow;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_char_code = 8'd0;
    logic                  i_line_end  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_address_class;
    logic [TotalWidth-1:0] o_ipv4_total;
    logic [TotalWidth-1:0] o_ipv6_total;
    logic [TotalWidth-1:0] o_invalid_total;

    t_line_state           line_st  = LineClear;
    logic [CountWidth-1:0] v4_count  = '0;
    logic [CountWidth-1:0] v6_count  = '0;
    logic [CountWidth-1:0] bad_count = '0;
    t_verdict              pending_verdicts [$];

    int    fail_count  = 0;
    int    cycle_count = 0;
    int    words_sent  = 0;
    int    lines_sent  = 0;
    int    seen_v4     = 0;
    int    seen_v6     = 0;
    int    seen_bad    = 0;
    int    burst_left  = 0;
    logic [5:0] stall_phase = '0;
    t_flow stall_mode  = FLOW_FREE;

    string hex_digits  = "0123456789abcdefABCDEF";
    string token_chars = "0123456789abcdefABCDEF.:.:.:g G/-";

    string directed_text [DirRows] = '{
        "",
        "0.0.0.0",
        "255.255.255.255",
        "10.0.200.1",
        "256.1.1.1",
        "99999.1.1.1",
        "1.2.3.4.5",
        "1.2.3.4.5.6.7.8.9",
        ".1.2.3",
        "1.2.3.",
        "1..2.3",
        "01.2.3.4",
        "1.2.3.4 ",
        "-1.2.3.4",
        "0:0:0:0:0:0:0:0",
        "ffff:FFFF:aAbB:9:0:cdef:1234:ABCD",
        "12345:0:0:0:0:0:0:0",
        "1:2:3:4:5:6:7:8:9",
        "::::::::::::::::::",
        "1:2:3:4:5:6:7:",
        "/@G`g:1:2:3:4:5:6:7",
        "1234"
    };

    int directed_class [DirRows] = '{
        CLASS_INVALID, CLASS_IPV4, CLASS_IPV4, CLASS_IPV4,
        CLASS_INVALID, CLASS_INVALID, CLASS_INVALID, CLASS_INVALID,
        CLASS_INVALID, CLASS_INVALID, CLASS_INVALID, CLASS_INVALID,
        CLASS_INVALID, CLASS_INVALID, CLASS_IPV6, CLASS_IPV6,
        CLASS_INVALID, CLASS_INVALID, ByModel, CLASS_INVALID,
        ByModel, ByModel
    };

    always #5 i_clk = ~i_clk;

    ip_address_text_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_line_end      (i_line_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_address_class (o_address_class),
        .o_ipv4_total    (o_ipv4_total),
        .o_ipv6_total    (o_ipv6_total),
        .o_invalid_total (o_invalid_total)
    );

    function void absorb_char(input logic [7:0] c);
        int   wide;
        logic is_digit;
        logic is_hex;
        is_digit = (c >= CharZero) && (c <= CharNine);
        is_hex   = is_digit || (c >= CharUpA && c <= CharUpF) ||
                   (c >= CharLoA && c <= CharLoF);
        // dotted decimal side
        if (c == CharDot) begin
            if (line_st.v4_empty || line_st.v4_value > V4FieldMax)
                line_st.v4_possible = 1'b0;
            if (line_st.dot_count < DotSat)
                line_st.dot_count = line_st.dot_count + 3'd1;
            if (line_st.dot_count > V4Dots)
                line_st.v4_possible = 1'b0;
            line_st.v4_empty     = 1'b1;
            line_st.v4_value     = '0;
            line_st.v4_lead_zero = 1'b0;
        end else if (is_digit) begin
            if (line_st.v4_lead_zero)
                line_st.v4_possible = 1'b0;
            if (line_st.v4_empty && c == CharZero)
                line_st.v4_lead_zero = 1'b1;
            wide = int'(line_st.v4_value) * 10 + int'(c - CharZero);
            line_st.v4_value = (wide > int'(V4FieldSat)) ? V4FieldSat : 9'(wide);
            if (line_st.v4_value > V4FieldMax)
                line_st.v4_possible = 1'b0;
            line_st.v4_empty = 1'b0;
        end else begin
            line_st.v4_possible = 1'b0;
        end
        // colon hex side
        if (c == CharColon) begin
            if (line_st.hex_count == '0)
                line_st.v6_possible = 1'b0;
            if (line_st.colon_count < ColonSat)
                line_st.colon_count = line_st.colon_count + 4'd1;
            if (line_st.colon_count > V6Colons)
                line_st.v6_possible = 1'b0;
            line_st.hex_count = '0;
        end else if (is_hex) begin
            if (line_st.hex_count >= HexMax)
                line_st.v6_possible = 1'b0;
            else
                line_st.hex_count = line_st.hex_count + 3'd1;
        end else begin
            line_st.v6_possible = 1'b0;
        end
    endfunction

    function t_verdict close_line();
        t_verdict v;
        logic     v4_ok;
        logic     v6_ok;
        v4_ok = line_st.v4_possible && line_st.dot_count == V4Dots &&
                !line_st.v4_empty && line_st.v4_value <= V4FieldMax;
        v6_ok = line_st.v6_possible && line_st.colon_count == V6Colons &&
                line_st.hex_count >= 3'd1 && line_st.hex_count <= HexMax;
        if (v4_ok) begin
            v.cls = CLASS_IPV4;
            if (v4_count != '1) v4_count = v4_count + 1'b1;
        end else if (v6_ok) begin
            v.cls = CLASS_IPV6;
            if (v6_count != '1) v6_count = v6_count + 1'b1;
        end else begin
            v.cls = CLASS_INVALID;
            if (bad_count != '1) bad_count = bad_count + 1'b1;
        end
        v.v4_total  = TotalWidth'(v4_count);
        v.v6_total  = TotalWidth'(v6_count);
        v.bad_total = TotalWidth'(bad_count);
        line_st = LineClear;
        return v;
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic eol, input int forced);
        t_verdict v;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        i_line_end  <= eol;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
        if (eol) begin
            v = close_line();
            if (forced != ByModel) v.cls = t_addr_class'(forced);
            pending_verdicts.insert(pending_verdicts.size(), v);
            lines_sent++;
        end else begin
            absorb_char(ch);
        end
    endtask

    task automatic send_text(input t_text txt, input int forced);
        foreach (txt[k]) send_word(txt[k], 1'b0, ByModel);
        // the end-of-line word carries a junk character
        send_word(8'($urandom_range(0, 255)), 1'b1, forced);
    endtask

    function automatic t_text make_line();
        t_text txt;
        string digits;
        int    kind;
        int    width;
        int    pos;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            for (int f = 0; f < 4; f++) begin
                if (f != 0) txt.insert(txt.size(), CharDot);
                case ($urandom_range(0, 9))
                    0:       digits = $sformatf("%0d", $urandom_range(256, 999));
                    1:       digits = $sformatf("0%0d", $urandom_range(0, 99));
                    2:       digits = "0";
                    default: digits = $sformatf("%0d", $urandom_range(0, 255));
                endcase
                for (int k = 0; k < digits.len(); k++) txt.insert(txt.size(), digits[k]);
            end
        end else if (kind < 75) begin
            for (int f = 0; f < 8; f++) begin
                if (f != 0) txt.insert(txt.size(), CharColon);
                width = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
                repeat (width) txt.insert(txt.size(), hex_digits[$urandom_range(0, 21)]);
            end
        end else if (kind < 88) begin
            repeat ($urandom_range(0, 24))
                txt.insert(txt.size(),
                           token_chars[$urandom_range(0, token_chars.len() - 1)]);
        end else begin
            repeat ($urandom_range(0, 12)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        // break some of the well-formed ones
        if (kind < 75 && $urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0:       txt[pos] = 8'($urandom_range(0, 255));
                1:       txt.delete(pos);
                default: txt.insert(pos, ($urandom_range(0, 1) != 0) ? CharDot : CharColon);
            endcase
        end
        return txt;
    endfunction

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no line pending: address_class %0d", o_address_class);
                fail_count++;
            end else begin
                v = pending_verdicts.pop_front();
                if (o_address_class != v.cls) begin
                    $error("address_class: expected %0d, got %0d", v.cls, o_address_class);
                    fail_count++;
                end
                if (o_ipv4_total != v.v4_total) begin
                    $error("ipv4_total: expected %0d, got %0d", v.v4_total, o_ipv4_total);
                    fail_count++;
                end
                if (o_ipv6_total != v.v6_total) begin
                    $error("ipv6_total: expected %0d, got %0d", v.v6_total, o_ipv6_total);
                    fail_count++;
                end
                if (o_invalid_total != v.bad_total) begin
                    $error("invalid_total: expected %0d, got %0d",
                           v.bad_total, o_invalid_total);
                    fail_count++;
                end
            end
            case (o_address_class)
                CLASS_IPV4: seen_v4++;
                CLASS_IPV6: seen_v6++;
                default:    seen_bad++;
            endcase
        end
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == '0) stall_mode <= t_flow'($urandom_range(0, 2));
        case (stall_mode)
            FLOW_FREE: i_out_ready <= 1'b1;
            FLOW_HALF: i_out_ready <= ($urandom_range(0, 1) != 0);
            default:   i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_text txt;
        int    random_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < DirRows; r++) begin
            txt.delete();
            for (int k = 0; k < directed_text[r].len(); k++)
                txt.insert(txt.size(), directed_text[r][k]);
            send_text(txt, directed_class[r]);
        end
        random_start = words_sent;
        while (words_sent - random_start < RandomWords ||
               lines_sent < DirRows + MinRandomLines)
            send_text(make_line(), ByModel);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("%0d lines in %0d words, %0d of them corner cases", lines_sent, words_sent,
                 DirRows);
        $display("verdicts seen: %0d ipv4, %0d ipv6, %0d invalid", seen_v4, seen_v6,
                 seen_bad);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
